// ===== rtl/core/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the phong light shading pipeline
// fixed point formats, register indexes and the per-item side-band word
// ----------------------------------------------------------------------------
package pls_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_VIEWER_X = 2'd0;
	localparam logic [1:0] REG_VIEWER_Y = 2'd1;
	localparam logic [1:0] REG_VIEWER_Z = 2'd2;

	// one in Q1.14
	localparam logic [14:0] Q14_ONE = 15'd16384;

	// the largest normalised magnitude sits in [2^29, 2^30)
	localparam int NORM_MSB = 29;

	// side-band data travelling with each item down the pipe
	typedef struct packed {
		logic              dgn;
		logic [14:0]       cos1;
		logic [7:0]        shin;
		logic [2:0][31:0]  idkd;
		logic [2:0][31:0]  isks;
	} pls_carry_t;

endpackage

// ===== rtl/core/phong_light_shade_unit.sv =====
// ----------------------------------------------------------------------------
// phong_light_shade_unit: per-light phong shading, fixed point
// diffuse plus specular for one light at one surface point per word
// ----------------------------------------------------------------------------
// Usage
// input channel (in_valid/in_ready) takes one shading word: normal, light
// direction, hit point, light and material colours and the shininess.
// output channel (out_valid/out_ready) returns red, green, blue in Q4.12
// and viewer_degenerate, which is set (with black colour) when the hit point
// equals the viewer position.
// the viewer position is written over the cfg channel (cfg_index 0..2 for
// x, y, z); cfg_ready is always high, unknown indexes are dropped.
// throughput: one word per cycle while the output is not stalled. the pipe
// depth is set by the 32-step square root, the 15-step divider and one power
// step per exponent bit.
// when out_ready is low with a word waiting, the whole pipe holds and
// in_ready falls; nothing is dropped or repeated.
// reset clears every valid bit and sets the viewer position to zero.
// ----------------------------------------------------------------------------
module phong_light_shade_unit
	import pls_pkg::*;
#(
	parameter int EXPONENT_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [47:0]        surface_normal,
	input  logic [47:0]        light_direction,
	input  logic signed [31:0] hit_x,
	input  logic signed [31:0] hit_y,
	input  logic signed [31:0] hit_z,
	input  logic [47:0]        light_diffuse,
	input  logic [47:0]        light_specular,
	input  logic [47:0]        material_diffuse,
	input  logic [47:0]        material_specular,
	input  logic [7:0]         shininess,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        red,
	output logic [15:0]        green,
	output logic [15:0]        blue,
	output logic               viewer_degenerate
);

	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 15;

	logic adv;

	// viewer position registers
	logic signed [31:0] viewer_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_q[0] <= '0;
			viewer_q[1] <= '0;
			viewer_q[2] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VIEWER_X: viewer_q[0] <= cfg_data;
				REG_VIEWER_Y: viewer_q[1] <= cfg_data;
				REG_VIEWER_Z: viewer_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// whole pipe moves unless the output word is stuck
	logic out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: differences and first products
	logic signed [31:0] hit_v [3];
	assign hit_v[0] = hit_x;
	assign hit_v[1] = hit_y;
	assign hit_v[2] = hit_z;

	logic               vld_s1;
	logic signed [32:0] d_s1 [3];
	logic signed [31:0] nl_s1 [3];
	logic signed [15:0] n_s1 [3];
	logic signed [15:0] l_s1 [3];
	pls_carry_t         car_s1;
	pls_carry_t         car_c1;

	// colour products for the side-band word
	always_comb begin
		car_c1 = '0;
		for (int i = 0; i < 3; i++) begin
			car_c1.idkd[i] = light_diffuse[16*i +: 16] * material_diffuse[16*i +: 16];
			car_c1.isks[i] = light_specular[16*i +: 16] * material_specular[16*i +: 16];
		end
		car_c1.shin = shininess;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= $signed({viewer_q[i][31], viewer_q[i]})
				          - $signed({hit_v[i][31], hit_v[i]});
				n_s1[i]  <= $signed(surface_normal[16*i +: 16]);
				l_s1[i]  <= $signed(light_direction[16*i +: 16]);
				nl_s1[i] <= $signed(surface_normal[16*i +: 16])
				          * $signed(light_direction[16*i +: 16]);
			end
			car_s1 <= car_c1;
		end
	end

	// ---------------- stage 2: magnitudes, largest, N.L
	logic               vld_s2;
	logic [32:0]        m_s2 [3];
	logic [2:0]         sgn_s2;
	logic [32:0]        mx_s2;
	logic signed [33:0] dnl_s2;
	logic signed [15:0] n_s2 [3];
	logic signed [15:0] l_s2 [3];
	pls_carry_t         car_s2;

	logic [32:0] m_c [3];
	logic [32:0] mx_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_c[i] = d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
		end
		mx_c = m_c[0];
		if (m_c[1] > mx_c) mx_c = m_c[1];
		if (m_c[2] > mx_c) mx_c = m_c[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m_s2[i]   <= m_c[i];
				sgn_s2[i] <= d_s1[i][32];
				n_s2[i]   <= n_s1[i];
				l_s2[i]   <= l_s1[i];
			end
			mx_s2  <= mx_c;
			dnl_s2 <= 34'(nl_s1[0]) + 34'(nl_s1[1]) + 34'(nl_s1[2]);
			car_s2 <= car_s1;
		end
	end

	// ---------------- stage 3: normalise by a power of two, cos1, 2(N.L)n
	logic               vld_s3;
	logic [29:0]        mn_s3 [3];
	logic [2:0]         sgn_s3;
	logic signed [50:0] p2_s3 [3];
	logic signed [15:0] l_s3 [3];
	pls_carry_t         car_s3;

	logic [5:0]         lead_c;
	logic [29:0]        mn_c [3];
	logic [14:0]        cos1_c;
	logic signed [19:0] dsh_c;
	logic signed [34:0] dnl2_c;
	pls_carry_t         car_c3;

	always_comb begin
		lead_c = '0;
		for (int b = 0; b < 33; b++) begin
			if (mx_s2[b]) lead_c = 6'(b);
		end
		for (int i = 0; i < 3; i++) begin
			if (lead_c > 6'(NORM_MSB))
				mn_c[i] = 30'(m_s2[i] >> (lead_c - 6'(NORM_MSB)));
			else
				mn_c[i] = 30'({30'b0, m_s2[i]} << (6'(NORM_MSB) - lead_c));
		end
		dsh_c = 20'(dnl_s2 >>> 14);
		if (dnl_s2 <= 0)
			cos1_c = '0;
		else if (dsh_c > $signed({5'b0, Q14_ONE}))
			cos1_c = Q14_ONE;
		else
			cos1_c = dsh_c[14:0];
		dnl2_c = $signed({dnl_s2, 1'b0});
		car_c3      = car_s2;
		car_c3.dgn  = (mx_s2 == '0);
		car_c3.cos1 = cos1_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mn_s3[i] <= mn_c[i];
				p2_s3[i] <= dnl2_c * n_s2[i];
				l_s3[i]  <= l_s2[i];
			end
			sgn_s3 <= sgn_s2;
			car_s3 <= car_c3;
		end
	end

	// ---------------- stage 4: reflected vector, squares
	logic               vld_s4;
	logic signed [23:0] r_s4 [3];
	logic signed [30:0] sm_s4 [3];
	logic [59:0]        sq_s4 [3];
	pls_carry_t         car_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				r_s4[i]  <= 24'(p2_s3[i] >>> 28) - 24'(l_s3[i]);
				sq_s4[i] <= mn_s3[i] * mn_s3[i];
				sm_s4[i] <= sgn_s3[i] ? -$signed({1'b0, mn_s3[i]}) : $signed({1'b0, mn_s3[i]});
			end
			car_s4 <= car_s3;
		end
	end

	// ---------------- stage 5: R.D products, sum of squares
	logic               vld_s5;
	logic signed [54:0] rvp_s5 [3];
	logic [61:0]        sumsq_s5;
	pls_carry_t         car_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				rvp_s5[i] <= r_s4[i] * sm_s4[i];
			end
			sumsq_s5 <= 62'(sq_s4[0]) + 62'(sq_s4[1]) + 62'(sq_s4[2]);
			car_s5   <= car_s4;
		end
	end

	// ---------------- stage 6: R.D sum, enters the square root
	logic               sq_vld [SQ_STEPS+1];
	logic [63:0]        sq_rem [SQ_STEPS+1];
	logic [63:0]        sq_res [SQ_STEPS+1];
	logic signed [56:0] sq_rv  [SQ_STEPS+1];
	pls_carry_t         sq_car [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld[0] <= 1'b0;
		end else if (adv) begin
			sq_vld[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_rv[0]  <= 57'(rvp_s5[0]) + 57'(rvp_s5[1]) + 57'(rvp_s5[2]);
			sq_rem[0] <= 64'(sumsq_s5);
			sq_res[0] <= '0;
			sq_car[0] <= car_s5;
		end
	end

	// ---------------- integer square root, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] SQ_BIT = 64'(1) << (62 - 2*k);
		logic [63:0] trial;
		assign trial = sq_res[k] + SQ_BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else if (adv) begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (sq_rem[k] >= trial) begin
					sq_rem[k+1] <= sq_rem[k] - trial;
					sq_res[k+1] <= (sq_res[k] >> 1) + SQ_BIT;
				end else begin
					sq_rem[k+1] <= sq_rem[k];
					sq_res[k+1] <= sq_res[k] >> 1;
				end
				sq_rv[k+1]  <= sq_rv[k];
				sq_car[k+1] <= sq_car[k];
			end
		end
	end

	// ---------------- divider entry: sign and saturation check
	logic        dv_vld [DV_STEPS+1];
	logic [55:0] dv_rem [DV_STEPS+1];
	logic [14:0] dv_q   [DV_STEPS+1];
	logic [31:0] dv_len [DV_STEPS+1];
	logic        dv_sat [DV_STEPS+1];
	logic        dv_neg [DV_STEPS+1];
	pls_carry_t  dv_car [DV_STEPS+1];

	logic [31:0] len_c;
	assign len_c = sq_res[SQ_STEPS][31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else if (adv) begin
			dv_vld[0] <= sq_vld[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_neg[0] <= sq_rv[SQ_STEPS][56];
			dv_rem[0] <= sq_rv[SQ_STEPS][55:0];
			dv_sat[0] <= sq_rv[SQ_STEPS][55:0] >= 56'({len_c, 15'b0});
			dv_len[0] <= len_c;
			dv_q[0]   <= '0;
			dv_car[0] <= sq_car[SQ_STEPS];
		end
	end

	// ---------------- restoring division, one quotient bit per stage
	for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
		localparam int QB = DV_STEPS - 1 - j;
		logic [55:0] dsub;
		assign dsub = 56'(dv_len[j]) << QB;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[j+1] <= 1'b0;
			end else if (adv) begin
				dv_vld[j+1] <= dv_vld[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (dv_rem[j] >= dsub) begin
					dv_rem[j+1] <= dv_rem[j] - dsub;
					dv_q[j+1]   <= dv_q[j] | (15'(1) << QB);
				end else begin
					dv_rem[j+1] <= dv_rem[j];
					dv_q[j+1]   <= dv_q[j];
				end
				dv_len[j+1] <= dv_len[j];
				dv_sat[j+1] <= dv_sat[j];
				dv_neg[j+1] <= dv_neg[j];
				dv_car[j+1] <= dv_car[j];
			end
		end
	end

	// ---------------- power entry: clamped specular cosine
	logic        pw_vld [EXPONENT_BITS+1];
	logic [14:0] pw_r   [EXPONENT_BITS+1];
	logic [14:0] pw_b   [EXPONENT_BITS+1];
	logic        pw_neg [EXPONENT_BITS+1];
	pls_carry_t  pw_car [EXPONENT_BITS+1];

	logic [14:0] cos2_c;
	always_comb begin
		if (dv_sat[DV_STEPS] || dv_q[DV_STEPS] > Q14_ONE)
			cos2_c = Q14_ONE;
		else
			cos2_c = dv_q[DV_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_vld[0] <= 1'b0;
		end else if (adv) begin
			pw_vld[0] <= dv_vld[DV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pw_r[0]   <= Q14_ONE;
			pw_b[0]   <= cos2_c;
			pw_neg[0] <= dv_neg[DV_STEPS];
			pw_car[0] <= dv_car[DV_STEPS];
		end
	end

	// ---------------- square and multiply, one exponent bit per stage
	for (genvar e = 0; e < EXPONENT_BITS; e++) begin : g_pow
		logic        ebit;
		logic [29:0] rr;
		logic [29:0] bb;
		if (e < 8) begin : g_bit
			assign ebit = pw_car[e].shin[e];
		end else begin : g_zero
			assign ebit = 1'b0;
		end
		assign rr = pw_r[e] * pw_b[e];
		assign bb = pw_b[e] * pw_b[e];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pw_vld[e+1] <= 1'b0;
			end else if (adv) begin
				pw_vld[e+1] <= pw_vld[e];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pw_r[e+1]   <= ebit ? rr[28:14] : pw_r[e];
				pw_b[e+1]   <= bb[28:14];
				pw_neg[e+1] <= pw_neg[e];
				pw_car[e+1] <= pw_car[e];
			end
		end
	end

	// ---------------- colour products
	logic        vld_ca;
	logic [46:0] dt_ca [3];
	logic [46:0] st_ca [3];
	logic        dgn_ca;
	logic [14:0] spec_c;
	pls_carry_t  pcar_c;

	assign pcar_c = pw_car[EXPONENT_BITS];
	assign spec_c = pw_neg[EXPONENT_BITS] ? 15'd0 : pw_r[EXPONENT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ca <= 1'b0;
		end else if (adv) begin
			vld_ca <= pw_vld[EXPONENT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dt_ca[i] <= pcar_c.idkd[i] * pcar_c.cos1;
				st_ca[i] <= pcar_c.isks[i] * spec_c;
			end
			dgn_ca <= pcar_c.dgn;
		end
	end

	// ---------------- output register: sum, scale, saturate
	logic [15:0] col_q [3];
	logic        dgn_q;
	logic [47:0] csum_c [3];
	logic [21:0] cshr_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			csum_c[i] = 48'(dt_ca[i]) + 48'(st_ca[i]);
			cshr_c[i] = csum_c[i][47:26];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_ca;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (dgn_ca)
					col_q[i] <= '0;
				else if (cshr_c[i] > 22'hFFFF)
					col_q[i] <= 16'hFFFF;
				else
					col_q[i] <= cshr_c[i][15:0];
			end
			dgn_q <= dgn_ca;
		end
	end

	assign out_valid         = out_valid_q;
	assign red               = col_q[0];
	assign green             = col_q[1];
	assign blue              = col_q[2];
	assign viewer_degenerate = dgn_q;

	// ---------------- checks
	a_dgn_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && viewer_degenerate |-> red == '0 && green == '0 && blue == '0)
		else $error("degenerate viewer word carries colour");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld[SQ_STEPS] && !sq_car[SQ_STEPS].dgn |-> len_c >= 32'h2000_0000)
		else $error("viewer length below normalised range");

	a_cos1_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> car_s3.cos1 <= Q14_ONE)
		else $error("diffuse cosine above one");

	a_pow_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		pw_vld[EXPONENT_BITS] |-> pw_r[EXPONENT_BITS] <= Q14_ONE)
		else $error("specular power above one");

endmodule

// ===== bench/tb_phong_light_shade_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phong_light_shade_unit: self-checking bench for the phong shading unit
// drives shading words with random gaps and output stalls, predicts each
// colour in fixed point and checks every returned word in order, across
// several viewer positions including the extremes of the register range
// ----------------------------------------------------------------------------
module tb_phong_light_shade_unit;
	import pls_pkg::*;

	localparam int SHIN_BITS = 8;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 6000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	// one shading word as offered on the input channel
	typedef struct {
		logic [47:0]        normal;
		logic [47:0]        light_dir;
		logic signed [31:0] hx;
		logic signed [31:0] hy;
		logic signed [31:0] hz;
		logic [47:0]        li_diff;
		logic [47:0]        li_spec;
		logic [47:0]        mat_diff;
		logic [47:0]        mat_spec;
		logic [7:0]         shin;
	} shade_word_t;

	// one colour word as returned
	typedef struct {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic        dgn;
	} colour_t;

	// expected-colour store with its own copy of the viewer position
	class colour_scoreboard;
		logic signed [31:0] view[3];
		colour_t colour_q[$];
		int errors;
		int checked;
		int degenerate_seen;

		function new();
			view[0] = '0;
			view[1] = '0;
			view[2] = '0;
			errors = 0;
			checked = 0;
			degenerate_seen = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			if (idx == REG_VIEWER_X) view[0] = val;
			else if (idx == REG_VIEWER_Y) view[1] = val;
			else if (idx == REG_VIEWER_Z) view[2] = val;
		endfunction

		function longint unsigned int_root(longint unsigned v);
			longint unsigned res;
			longint unsigned bt;
			res = 0;
			bt = 64'd1 << 62;
			while (bt > v) bt = bt >> 2;
			while (bt != 0) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			return res;
		endfunction

		function longint unsigned q14_power(longint unsigned base, longint unsigned e);
			longint unsigned acc;
			acc = 16384;
			while (e != 0) begin
				if (e[0]) acc = (acc * base) >> 14;
				base = (base * base) >> 14;
				e = e >> 1;
			end
			return acc;
		endfunction

		// fixed point phong colour for one word
		function colour_t shade(shade_word_t w);
			longint d[3];
			longint mg[3];
			longint nv[3];
			longint lv[3];
			longint rv_c;
			longint sm;
			longint dnl;
			longint rv;
			longint mx;
			longint unsigned sumsq;
			longint unsigned len;
			longint unsigned cos1;
			longint unsigned spec;
			longint unsigned c;
			longint unsigned id, is, kd, ks, sum;
			logic [15:0] ch[3];
			colour_t res;
			d[0] = longint'(view[0]) - longint'(w.hx);
			d[1] = longint'(view[1]) - longint'(w.hy);
			d[2] = longint'(view[2]) - longint'(w.hz);
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				mg[i] = (d[i] < 0) ? -d[i] : d[i];
				if (mg[i] > mx) mx = mg[i];
			end
			// hit point on the viewer: black with the flag
			if (mx == 0) begin
				res.r = '0;
				res.g = '0;
				res.b = '0;
				res.dgn = 1'b1;
				return res;
			end
			// normalise so the largest magnitude sits in [2^29, 2^30)
			while (mx >= (64'sd1 << 30)) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
			end
			while (mx < (64'sd1 << 29)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
			end
			sumsq = 0;
			for (int i = 0; i < 3; i++) sumsq += longint'(mg[i]) * longint'(mg[i]);
			len = int_root(sumsq);
			dnl = 0;
			for (int i = 0; i < 3; i++) begin
				nv[i] = longint'($signed(w.normal[16*i +: 16]));
				lv[i] = longint'($signed(w.light_dir[16*i +: 16]));
				dnl += nv[i] * lv[i];
			end
			// reflect the light about the normal and dot with the view
			rv = 0;
			for (int i = 0; i < 3; i++) begin
				sm = (d[i] < 0) ? -mg[i] : mg[i];
				rv_c = ((2 * dnl * nv[i]) >>> 28) - lv[i];
				rv += rv_c * sm;
			end
			if (dnl <= 0) begin
				cos1 = 0;
			end else begin
				cos1 = longint'(dnl) >> 14;
				if (cos1 > 16384) cos1 = 16384;
			end
			if (rv < 0) begin
				spec = 0;
			end else begin
				c = longint'(rv) / len;
				if (c > 16384) c = 16384;
				spec = q14_power(c, w.shin & ((1 << SHIN_BITS) - 1));
			end
			for (int i = 0; i < 3; i++) begin
				id = w.li_diff[16*i +: 16];
				is = w.li_spec[16*i +: 16];
				kd = w.mat_diff[16*i +: 16];
				ks = w.mat_spec[16*i +: 16];
				sum = (id * kd * cos1 + is * ks * spec) >> 26;
				ch[i] = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
			end
			res.r = ch[0];
			res.g = ch[1];
			res.b = ch[2];
			res.dgn = 1'b0;
			return res;
		endfunction

		function void note_word(shade_word_t w);
			colour_t e;
			e = shade(w);
			colour_q = {colour_q, e};
		endfunction

		function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_word(colour_t got);
			colour_t e;
			if (colour_q.size() == 0) begin
				errors++;
				$display("%0t unexpected word: expected none actual %h %h %h %b",
					$time, got.r, got.g, got.b, got.dgn);
				return;
			end
			e = colour_q.pop_front();
			checked++;
			if (e.dgn) degenerate_seen++;
			cmp_field("red", e.r, got.r);
			cmp_field("green", e.g, got.g);
			cmp_field("blue", e.b, got.b);
			cmp_field("viewer_degenerate", {15'd0, e.dgn}, {15'd0, got.dgn});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [47:0] surface_normal = '0;
	logic [47:0] light_direction = '0;
	logic signed [31:0] hit_x = '0;
	logic signed [31:0] hit_y = '0;
	logic signed [31:0] hit_z = '0;
	logic [47:0] light_diffuse = '0;
	logic [47:0] light_specular = '0;
	logic [47:0] material_diffuse = '0;
	logic [47:0] material_specular = '0;
	logic [7:0] shininess = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] red, green, blue;
	logic viewer_degenerate;

	colour_scoreboard sb = new();
	logic signed [31:0] vw[3];
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_req = 1'b0;
	int hold_len = 0;
	int words_sent = 0;
	int idle_cycles = 0;

	phong_light_shade_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.surface_normal(surface_normal), .light_direction(light_direction),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.light_diffuse(light_diffuse), .light_specular(light_specular),
		.material_diffuse(material_diffuse), .material_specular(material_specular),
		.shininess(shininess),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue),
		.viewer_degenerate(viewer_degenerate)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", idle_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		int stall;
		colour_t got;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			got.r = red;
			got.g = green;
			got.b = blue;
			got.dgn = viewer_degenerate;
			sb.check_word(got);
		end
	end

	// register write, called on a falling edge with the pipe empty
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		if (idx == REG_VIEWER_X) vw[0] = val;
		else if (idx == REG_VIEWER_Y) vw[1] = val;
		else if (idx == REG_VIEWER_Z) vw[2] = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// offer one word after a gap, called on a falling edge
	task automatic send_word(shade_word_t w);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		surface_normal = w.normal;
		light_direction = w.light_dir;
		hit_x = w.hx;
		hit_y = w.hy;
		hit_z = w.hz;
		light_diffuse = w.li_diff;
		light_specular = w.li_spec;
		material_diffuse = w.mat_diff;
		material_specular = w.mat_spec;
		shininess = w.shin;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait for every outstanding colour
	task automatic drain();
		in_valid = 1'b0;
		while (sb.colour_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [47:0] pack3(int a, int b, int c);
		logic [15:0] x, y, z;
		x = 16'(a);
		y = 16'(b);
		z = 16'(c);
		return {z, y, x};
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// vector: raw bits, components each -1, 0 or 1, or components within one
	function automatic logic [47:0] rand_vec();
		int s[3];
		case ($urandom_range(0, 3))
			0: return rand48();
			1: begin
				for (int i = 0; i < 3; i++)
					s[i] = 16384 * ($signed($urandom_range(0, 2)) - 1);
				return pack3(s[0], s[1], s[2]);
			end
			default: begin
				for (int i = 0; i < 3; i++)
					s[i] = $signed($urandom_range(0, 32768)) - 16384;
				return pack3(s[0], s[1], s[2]);
			end
		endcase
	endfunction

	// hit coordinate: near the viewer mostly, sometimes anywhere
	function automatic logic signed [31:0] rand_hit(logic signed [31:0] v, bit same);
		if (same) return v;
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return v + ($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
			2: return v + ($signed($urandom_range(0, 64)) - 32);
			default: return v + ($signed($urandom()) >>> $urandom_range(0, 31));
		endcase
	endfunction

	function automatic logic [47:0] rand_colour();
		if ($urandom_range(0, 2) == 0) return rand48();
		return pack3($urandom_range(0, 8192), $urandom_range(0, 8192),
			$urandom_range(0, 8192));
	endfunction

	function automatic shade_word_t rand_word();
		shade_word_t w;
		bit same;
		same = ($urandom_range(0, 29) == 0);
		w.normal = rand_vec();
		w.light_dir = ($urandom_range(0, 3) == 0) ? w.normal : rand_vec();
		w.hx = rand_hit(vw[0], same);
		w.hy = rand_hit(vw[1], same);
		w.hz = rand_hit(vw[2], same);
		w.li_diff = rand_colour();
		w.li_spec = rand_colour();
		w.mat_diff = rand_colour();
		w.mat_spec = rand_colour();
		w.shin = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 16));
		return w;
	endfunction

	function automatic shade_word_t fixed_word(logic [47:0] nrm, logic [47:0] ldir,
		logic signed [31:0] z, logic [47:0] col, logic [7:0] shin);
		shade_word_t w;
		w.normal = nrm;
		w.light_dir = ldir;
		w.hx = '0;
		w.hy = '0;
		w.hz = z;
		w.li_diff = col;
		w.li_spec = col;
		w.mat_diff = col;
		w.mat_spec = col;
		w.shin = shin;
		return w;
	endfunction

	// stimulus and phase control
	initial begin
		logic [47:0] up, down, one;
		logic signed [31:0] phase_view[7][3];
		shade_word_t w;
		vw[0] = '0;
		vw[1] = '0;
		vw[2] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		up = pack3(0, 0, 16384);
		down = pack3(0, 0, -16384);
		one = pack3(4096, 4096, 4096);
		// directed words with the viewer at the origin
		send_word(fixed_word(up, up, 32'sd0, one, 8'd1));
		send_word(fixed_word(up, up, -32'sd65536, one, 8'd0));
		send_word(fixed_word(up, up, -32'sd65536, one, 8'd1));
		send_word(fixed_word(up, up, -32'sd65536, one, 8'd255));
		send_word(fixed_word(up, down, -32'sd65536, one, 8'd3));
		send_word(fixed_word(up, pack3(16384, 0, 0), -32'sd65536, one, 8'd7));
		send_word(fixed_word(up, up, -32'sd65536, 48'hFFFF_FFFF_FFFF, 8'd2));
		send_word(fixed_word(up, up, -32'sd65536, 48'd0, 8'd2));
		send_word(fixed_word(pack3(32767, 32767, 32767), pack3(32767, 32767, 32767),
			-32'sd1, one, 8'd4));
		send_word(fixed_word(pack3(-32768, -32768, -32768), pack3(-32768, 32767, -32768),
			32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd128));
		send_word(fixed_word(up, up, 32'sh8000_0000, one, 8'd5));
		send_word(fixed_word(down, down, 32'sh7FFF_FFFF, one, 8'd5));
		send_word(fixed_word(up, pack3(11585, 0, 11585), -32'sd1, one, 8'd16));
		w = fixed_word(pack3(0, 16384, 0), pack3(0, 11585, 11585), 32'sd0, one, 8'd9);
		w.hx = 32'sh8000_0000;
		w.hy = 32'sh7FFF_FFFF;
		send_word(w);
		w = fixed_word(up, up, 32'sd0, one, 8'd1);
		w.hy = 32'sd1;
		send_word(w);
		drain();
		// a write to the spare index must leave the viewer alone
		write_reg(REG_SPARE, 32'h1234_5678);
		send_word(fixed_word(up, up, 32'sd0, one, 8'd1));
		drain();

		phase_view[0] = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		phase_view[1] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		phase_view[2] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0};
		phase_view[3] = '{32'sd0, 32'sd0, 32'sd0};
		for (int p = 4; p < 7; p++)
			for (int k = 0; k < 3; k++) phase_view[p][k] = $urandom();

		for (int p = 0; p < 7; p++) begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			write_reg(REG_VIEWER_X, phase_view[p][0]);
			write_reg(REG_VIEWER_Y, phase_view[p][1]);
			write_reg(REG_VIEWER_Z, phase_view[p][2]);
			for (int chunk = 0; chunk < 5; chunk++) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
				// hold the output long enough for the pipe to back up
				if (p == 2 && chunk == 1) begin
					hold_len = 300;
					hold_req = 1'b1;
					tx_burst = 1'b1;
				end
				repeat (50) send_word(rand_word());
			end
			drain();
		end

		tx_burst = 1'b0;
		rx_burst = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("sent %0d shading words over 8 viewer settings, %0d colours checked",
			words_sent, sb.checked);
		$display("degenerate viewer cases seen: %0d, mismatches: %0d",
			sb.degenerate_seen, sb.errors);
		if (sb.errors == 0 && sb.colour_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
